### hw/rtl/assert_macros.svh
// Assertion macros used by the checker module of this block.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/bbc_pkg.sv
// Shared types and constants for the bracket balance checker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package bbc_pkg;

    // Bracket kind codes kept on the stack.
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_ROUND  = 2'd0;
    localparam kind_t KIND_CURLY  = 2'd1;
    localparam kind_t KIND_SQUARE = 2'd2;
    localparam kind_t KIND_ANGLE  = 2'd3;

    // Status codes reported with every result.
    typedef logic [2:0] status_t;
    localparam status_t ST_OK        = 3'd0;
    localparam status_t ST_BALANCED  = 3'd1;
    localparam status_t ST_MISMATCH  = 3'd2;
    localparam status_t ST_UNMATCHED = 3'd3;
    localparam status_t ST_UNCLOSED  = 3'd4;
    localparam status_t ST_OVERFLOW  = 3'd5;

    // Bracket characters in ASCII.
    localparam logic [7:0] CHAR_OPEN_ROUND   = 8'h28;
    localparam logic [7:0] CHAR_CLOSE_ROUND  = 8'h29;
    localparam logic [7:0] CHAR_OPEN_CURLY   = 8'h7B;
    localparam logic [7:0] CHAR_CLOSE_CURLY  = 8'h7D;
    localparam logic [7:0] CHAR_OPEN_SQUARE  = 8'h5B;
    localparam logic [7:0] CHAR_CLOSE_SQUARE = 8'h5D;
    localparam logic [7:0] CHAR_OPEN_ANGLE   = 8'h3C;
    localparam logic [7:0] CHAR_CLOSE_ANGLE  = 8'h3E;

    // Width of the reported depth field.
    localparam int DEPTH_OUT_W = 7;

    // One input transaction.
    typedef struct packed {
        logic [7:0] char_in;
        logic       is_last;
    } in_t;

    // One classified operation handed from the front to the back.
    typedef struct packed {
        logic  is_open;
        logic  is_close;
        kind_t kind;
        logic  last;
    } op_t;

    // One result transaction.
    typedef struct packed {
        status_t                  status;
        logic [DEPTH_OUT_W-1:0]   depth;
        logic                     final_res;
    } res_t;

endpackage

`default_nettype wire

### hw/rtl/bbc_front.sv
// Front end of the bracket balance checker: classifies characters into stack
// operations and holds them in a two-entry queue. Depends on bbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bbc_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  bbc_pkg::in_t  item,
    output logic          op_valid,
    output bbc_pkg::op_t  op,
    input  logic          op_take
);
    import bbc_pkg::*;

    op_t        op_class;
    op_t        queue_mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       wr_en;

    // Decode the character into an opener, a closer or nothing.
    always_comb
    begin
        op_class          = '0;
        op_class.last     = item.is_last;
        case (item.char_in)
            CHAR_OPEN_ROUND:
            begin
                op_class.is_open = 1'b1;
                op_class.kind    = KIND_ROUND;
            end
            CHAR_OPEN_CURLY:
            begin
                op_class.is_open = 1'b1;
                op_class.kind    = KIND_CURLY;
            end
            CHAR_OPEN_SQUARE:
            begin
                op_class.is_open = 1'b1;
                op_class.kind    = KIND_SQUARE;
            end
            CHAR_OPEN_ANGLE:
            begin
                op_class.is_open = 1'b1;
                op_class.kind    = KIND_ANGLE;
            end
            CHAR_CLOSE_ROUND:
            begin
                op_class.is_close = 1'b1;
                op_class.kind     = KIND_ROUND;
            end
            CHAR_CLOSE_CURLY:
            begin
                op_class.is_close = 1'b1;
                op_class.kind     = KIND_CURLY;
            end
            CHAR_CLOSE_SQUARE:
            begin
                op_class.is_close = 1'b1;
                op_class.kind     = KIND_SQUARE;
            end
            CHAR_CLOSE_ANGLE:
            begin
                op_class.is_close = 1'b1;
                op_class.kind     = KIND_ANGLE;
            end
            default:
            begin
                op_class.is_open  = 1'b0;
                op_class.is_close = 1'b0;
            end
        endcase
    end

    // Queue bookkeeping: a transaction enters when not full, leaves when taken.
    always_comb
    begin
        full        = (count_reg == 2'd2);
        wr_en       = push && !full;
        op_valid    = (count_reg != 2'd0);
        op          = queue_mem[rd_ptr_reg];
        wr_ptr_next = wr_en ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = op_take ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, wr_en} - {1'b0, op_take};
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            queue_mem[wr_ptr_reg] <= op_class;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/bbc_back.sv
// Back end of the bracket balance checker: runs the kind stack, keeps the
// sticky error and queues results in a two-entry result queue. Depends on bbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bbc_back #(
    parameter int MAX_DEPTH = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          op_valid,
    input  bbc_pkg::op_t  op,
    output logic          op_take,
    output logic          empty,
    input  logic          pop,
    output bbc_pkg::res_t result
);
    import bbc_pkg::*;

    localparam int AW = $clog2(MAX_DEPTH);
    localparam int DW = $clog2(MAX_DEPTH + 1);

    kind_t         stack_mem [MAX_DEPTH];
    kind_t         top_reg;
    logic [DW-1:0] depth_reg;
    logic [DW-1:0] depth_next;
    logic [DW-1:0] depth_after;
    status_t       err_reg;
    status_t       err_next;
    status_t       err_step;
    logic          push_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    res_t          res_in;
    res_t          res_mem [2];
    logic          res_wr_ptr_reg;
    logic          res_rd_ptr_reg;
    logic [1:0]    res_count_reg;
    logic [1:0]    res_count_next;
    logic          out_pop;

    // Take an operation whenever the result queue has room, counting a pop this cycle.
    always_comb
    begin
        out_pop = pop && (res_count_reg != 2'd0);
        op_take = op_valid && ((res_count_reg != 2'd2) || out_pop);
        empty   = (res_count_reg == 2'd0);
        result  = res_mem[res_rd_ptr_reg];
    end

    // Stack step: push, pop with kind check, and the sticky error.
    always_comb
    begin
        push_en     = 1'b0;
        err_step    = err_reg;
        depth_after = depth_reg;
        depth_next  = depth_reg;
        err_next    = err_reg;
        res_in      = '0;
        if (op_take)
        begin
            if (err_reg == ST_OK)
            begin
                if (op.is_open)
                begin
                    if (depth_reg == DW'(MAX_DEPTH))
                    begin
                        err_step = ST_OVERFLOW;
                    end
                    else
                    begin
                        push_en     = 1'b1;
                        depth_after = depth_reg + DW'(1);
                    end
                end
                else if (op.is_close)
                begin
                    if (depth_reg == '0)
                    begin
                        err_step = ST_UNMATCHED;
                    end
                    else
                    begin
                        depth_after = depth_reg - DW'(1);
                        if (top_reg != op.kind)
                        begin
                            err_step = ST_MISMATCH;
                        end
                    end
                end
            end

            // Status reflects the step; the verdict comes only on the last character.
            if (err_step != ST_OK)
            begin
                res_in.status = err_step;
            end
            else if (!op.last)
            begin
                res_in.status = ST_OK;
            end
            else if (depth_after == '0)
            begin
                res_in.status = ST_BALANCED;
            end
            else
            begin
                res_in.status = ST_UNCLOSED;
            end
            res_in.depth     = DEPTH_OUT_W'(depth_after);
            res_in.final_res = op.last;

            // The last character clears the expression state.
            depth_next = op.last ? '0 : depth_after;
            err_next   = op.last ? ST_OK : err_step;
        end
    end

    // The read address tracks the top entry under the next depth.
    always_comb
    begin
        wr_addr = AW'(depth_reg);
        rd_addr = AW'(depth_next - DW'(1));
    end

    // Stack memory with a registered top; a fresh push bypasses the read.
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            stack_mem[wr_addr] <= op.kind;
        end
        if (push_en && !op.last)
        begin
            top_reg <= op.kind;
        end
        else
        begin
            top_reg <= stack_mem[rd_addr];
        end
    end

    // Stack depth and error state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
            err_reg   <= ST_OK;
        end
        else
        begin
            depth_reg <= depth_next;
            err_reg   <= err_next;
        end
    end

    // Result queue storage.
    always_ff @(posedge clk)
    begin
        if (op_take)
        begin
            res_mem[res_wr_ptr_reg] <= res_in;
        end
    end

    // Result queue pointers and fill count.
    always_comb
    begin
        res_count_next = res_count_reg + {1'b0, op_take} - {1'b0, out_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wr_ptr_reg <= 1'b0;
            res_rd_ptr_reg <= 1'b0;
            res_count_reg  <= 2'd0;
        end
        else
        begin
            if (op_take)
            begin
                res_wr_ptr_reg <= !res_wr_ptr_reg;
            end
            if (out_pop)
            begin
                res_rd_ptr_reg <= !res_rd_ptr_reg;
            end
            res_count_reg <= res_count_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/bracket_balance_checker_core.sv
// Bracket balance checker, top level.
// Joins the classifying front end and the stack back end. Depends on bbc_pkg.
//
// Usage:
//   Input channel: one character per transaction with a last-character flag,
//   taken when push is high and full is low. Result channel: one result per
//   character, shown while empty is low and taken when pop is high.
//   Each result carries the status, the stack depth after the character, and
//   final_res on the last character, which also clears the stack and error.
//   A character taken is held in the front queue, then its result is
//   registered in the result queue, from which it can be popped.
//   Throughput: one character per cycle while results are popped, set by the
//   single stack step in the back end, which reads and writes only the top of the stack memory.
//   Reset clears both queues, the depth and the error; the stack memory is
//   not cleared, as entries are always written before they are read.
//   When the receiver stops popping, two results wait in the result queue,
//   then the front queue fills and full rises after two more characters.
`timescale 1ns / 1ps
`default_nettype none

module bracket_balance_checker_core #(
    parameter int MAX_DEPTH = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  bbc_pkg::in_t  item,
    output logic          empty,
    input  logic          pop,
    output bbc_pkg::res_t result
);
    import bbc_pkg::*;

    op_t  op;
    logic op_valid;
    logic op_take;

    // Classify characters and queue the operations.
    bbc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .op_valid (op_valid),
        .op       (op),
        .op_take  (op_take)
    );

    // Run the stack and queue the results.
    bbc_back #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (op_valid),
        .op       (op),
        .op_take  (op_take),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

endmodule

`default_nettype wire

### hw/rtl/bbc_checker.sv
// Port-level checks for the bracket balance checker, bound to the top level.
// Depends on bbc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bbc_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          full,
    input logic          empty,
    input logic          pop,
    input bbc_pkg::res_t result
);
    import bbc_pkg::*;

    logic hold;
    logic status_known;
    logic verdict_fits;
    logic empty_stack_code;
    logic depth_fits;

    // Conditions on the result ports used by the checks below.
    assign hold         = !empty && !pop;
    assign status_known = (result.status == ST_OK)        || (result.status == ST_BALANCED) ||
                          (result.status == ST_MISMATCH)  || (result.status == ST_UNMATCHED) ||
                          (result.status == ST_UNCLOSED)  || (result.status == ST_OVERFLOW);
    assign verdict_fits = result.final_res ? (result.status != ST_OK) :
                          (result.status != ST_BALANCED && result.status != ST_UNCLOSED);
    assign empty_stack_code = (result.status == ST_BALANCED) ||
                              (result.status == ST_UNMATCHED);
    assign depth_fits       = !empty_stack_code || (result.depth == '0);

    // A waiting result that is not taken stays unchanged.
    `ASSERT_NEXT(a_result_held, clk, rst_n, hold, !empty && $stable(result), "held result moved")

    // Only defined status codes are reported.
    `ASSERT_IMPLIES(a_status_code, clk, rst_n, !empty, status_known, "undefined status code")

    // A verdict status never appears before the last character, and ok never on it.
    `ASSERT_IMPLIES(a_verdict_only_final, clk, rst_n, !empty, verdict_fits, "status vs final flag")

    // Balanced and unmatched-close results always come with an empty stack.
    `ASSERT_IMPLIES(a_empty_stack_codes, clk, rst_n, !empty, depth_fits, "bad depth for status")

    // The input side only backs up while a result is waiting (both slots hold one by then).
    `ASSERT_IMPLIES(a_full_backlog, clk, rst_n, full, !empty, "full with no result waiting")

endmodule

bind bracket_balance_checker_core bbc_checker u_bbc_checker (.*);

`default_nettype wire
